@@ design/ulrd_pkg.sv @@
// Shared constants and types of the USB link receive deframer.
package ulrd_pkg;

	// The fixed part of the header is six bytes: header length, payload length and packet id.
	localparam int unsigned HDR_MIN = 6;
	localparam logic [7:0] PAD_VALUE = 8'hAC;
	localparam logic [15:0] MAX_LEN_RESET = 16'd8191;

	localparam int unsigned TDATA_OUT_W = 48;

	// Verdict codes. When several checks fail, the lowest code is reported.
	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_BUS_ERROR    = 4'd1,
		ST_EVEN_LENGTH  = 4'd2,
		ST_TOO_LONG     = 4'd3,
		ST_LEN_TOO_BIG  = 4'd4,
		ST_HDR_SHORT    = 4'd5,
		ST_HDR_OVER_LEN = 4'd6,
		ST_BAD_PAD      = 4'd7,
		ST_LEN_MISMATCH = 4'd8,
		ST_ID_MISMATCH  = 4'd9,
		ST_EMPTY        = 4'd10
	} frame_status_t;

endpackage

@@ design/usb_link_rx_deframer.sv @@
// Receive deframer for one bulk transfer: header parse, payload pass-through, end-of-transfer verdict.
//
// Channel      Dir  Handshake                      Contents
// s_axis       in   s_axis_tvalid/s_axis_tready    one byte per request, tlast, tuser = bus error
// m_axis       out  m_axis_tvalid/m_axis_tready    payload byte or verdict, tuser = is_verdict
// cfg          in   cfg_valid/cfg_ready            max_packet_len
//
// The block sustains one byte per cycle while m_axis does not stall.
// The first stage is an input register. The second stage holds the header, index and pad state
// and loads the result register.
// An asynchronous reset clears valid and transfer state and sets max_packet_len to 8191. No clearing pass is needed.
// A stall on m_axis holds the input register, and backpressure then reaches s_axis in the same cycle.
module usb_link_rx_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	input  logic        s_axis_tuser,   // [0] transfer_error
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] payload_byte, [11:8] frame_status, [27:12] frame_id,
	// [43:28] frame_length, [47:44] zero
	output logic [ulrd_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
	output logic        m_axis_tuser,   // [0] is_verdict
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data        // max_packet_len
);
	import ulrd_pkg::*;

	// Configuration register. The user must write it only while the block is idle; the block does not enforce this.
	logic [15:0] max_len_q;

	// Input stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        err_s1;

	// Per-transfer state.
	logic [15:0] idx_q;
	logic [15:0] hdr_len_q;
	logic [15:0] pay_len_q;
	logic [15:0] hdr_id_q;
	logic [7:0]  prev_q;
	logic        pad_ok_q;

	// Result register.
	logic        out_valid_q;
	logic        out_verdict_q;
	logic [7:0]  out_byte_q;
	frame_status_t out_status_q;
	logic [15:0] out_id_q;
	logic [15:0] out_len_q;

	logic        advance;
	logic [15:0] hl_n, pl_n, id_n;
	logic [16:0] hl_plus_pl;
	logic        at_pad, pad_ok_n;
	logic        in_payload, emit;
	logic [16:0] total;
	logic [17:0] expected;
	logic        pad_needed;
	logic [15:0] trailer_id;
	frame_status_t status;

	assign cfg_ready = 1'b1;

	// The second stage consumes the held byte whenever the result register is free or is being
	// drained in this cycle.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
			err_s1  <= s_axis_tuser;
		end
	end

	// Capture the header fields in the order they arrive, low byte first. The final byte may
	// itself complete a field, so later checks use these updated values.
	always_comb begin
		hl_n = hdr_len_q;
		pl_n = pay_len_q;
		id_n = hdr_id_q;
		case (idx_q)
			16'd0:   hl_n = {8'd0, byte_s1};
			16'd1:   hl_n = {byte_s1, hdr_len_q[7:0]};
			16'd2:   pl_n = {8'd0, byte_s1};
			16'd3:   pl_n = {byte_s1, pay_len_q[7:0]};
			16'd4:   id_n = {8'd0, byte_s1};
			16'd5:   id_n = {byte_s1, hdr_id_q[7:0]};
			default: ;
		endcase
	end

	assign hl_plus_pl = {1'b0, hl_n} + {1'b0, pl_n};
	assign at_pad     = (idx_q >= 16'(HDR_MIN)) && ({1'b0, idx_q} == hl_plus_pl);
	assign pad_ok_n   = at_pad ? (byte_s1 == PAD_VALUE) : pad_ok_q;
	assign in_payload = (idx_q >= 16'(HDR_MIN)) && (idx_q >= hl_n) && ({1'b0, idx_q} < hl_plus_pl);
	assign emit       = !last_s1 && in_payload;

	// After the index saturates, the total length reads as 65536.
	assign total      = {1'b0, idx_q} + 17'd1;
	assign pad_needed = !pl_n[0];
	assign expected   = {1'b0, hl_plus_pl} + 18'd2 + {17'd0, pad_needed};
	assign trailer_id = {byte_s1, prev_q};

	// The verdict checks follow the priority of the status codes.
	always_comb begin
		if (err_s1)                            status = ST_BUS_ERROR;
		else if (!total[0])                    status = ST_EVEN_LENGTH;
		else if (total > {1'b0, max_len_q})    status = ST_TOO_LONG;
		else if (pl_n > max_len_q)             status = ST_LEN_TOO_BIG;
		else if (hl_n < 16'(HDR_MIN))          status = ST_HDR_SHORT;
		else if (hl_n > pl_n)                  status = ST_HDR_OVER_LEN;
		else if (pad_needed && !pad_ok_n)      status = ST_BAD_PAD;
		else if ({1'b0, total} != expected)    status = ST_LEN_MISMATCH;
		else if (id_n != trailer_id)           status = ST_ID_MISMATCH;
		else if (pl_n == 16'd0)                status = ST_EMPTY;
		else                                   status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			hdr_len_q <= '0;
			pay_len_q <= '0;
			hdr_id_q  <= '0;
			prev_q    <= '0;
			pad_ok_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				idx_q     <= '0;
				hdr_len_q <= '0;
				pay_len_q <= '0;
				hdr_id_q  <= '0;
				prev_q    <= '0;
				pad_ok_q  <= 1'b0;
			end else begin
				hdr_len_q <= hl_n;
				pay_len_q <= pl_n;
				hdr_id_q  <= id_n;
				prev_q    <= byte_s1;
				pad_ok_q  <= pad_ok_n;
				if (idx_q != 16'hFFFF) begin
					idx_q <= idx_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && (last_s1 || emit)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (last_s1 || emit)) begin
			out_verdict_q <= last_s1;
			if (last_s1) begin
				out_byte_q   <= '0;
				out_status_q <= status;
				out_id_q     <= id_n;
				out_len_q    <= pl_n;
			end else begin
				out_byte_q   <= byte_s1;
				out_status_q <= ST_OK;
				out_id_q     <= '0;
				out_len_q    <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_verdict_q;
	assign m_axis_tdata  = {4'd0, out_len_q, out_id_q, out_status_q, out_byte_q};

	// A verdict never carries a code beyond the last defined one.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[11:8] <= ST_EMPTY))
		else $error("verdict status out of range");

	// A payload item carries zeros in all verdict fields.
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[43:8] == '0))
		else $error("payload item carries verdict fields");

	// The final byte of a transfer rearms the parser for the next one.
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> (idx_q == '0) && !pad_ok_q)
		else $error("transfer state not cleared after final byte");

	// Within a transfer the byte index never moves backward.
	a_index_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 |=> (idx_q >= $past(idx_q)) && (idx_q != '0))
		else $error("byte index moved backward");

	// A consumed final byte always results in a verdict.
	a_verdict_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> m_axis_tvalid && m_axis_tuser)
		else $error("final byte gave no verdict");

endmodule

@@ test/usb_link_rx_deframer_tb.sv @@
// Self-checking testbench for the USB link receive deframer: directed frames, limits, stalls, random traffic.
module usb_link_rx_deframer_tb;
	import ulrd_pkg::*;

	// One expected request on the output stream.
	typedef struct {
		bit            is_verdict;
		bit [7:0]      payload_byte;
		frame_status_t frame_status;
		bit [15:0]     frame_id;
		bit [15:0]     frame_length;
	} deframe_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [15:0]            cfg_data = '0;

	usb_link_rx_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Predicted results still waiting for the block, oldest first.
	deframe_result_t pending_results[$];

	// Shadow of the block's register and per-transfer state.
	bit [15:0] shadow_max_len = MAX_LEN_RESET;
	bit [15:0] rx_pos;
	bit [15:0] rx_hdr_len;
	bit [15:0] rx_pay_len;
	bit [15:0] rx_hdr_id;
	bit [7:0]  rx_prev_byte;
	bit        rx_pad_ok;

	// Transfer being assembled for the sender.
	bit [7:0] tx_frame[$];

	int  mismatch_count = 0;
	int  bytes_sent = 0;
	int  idle_cycles = 0;
	bit  tx_steady = 1'b0;
	bit  rx_steady = 1'b0;
	int  rx_hold_len = 0;
	int  rx_stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Verdict of a finished transfer; the first failing check wins.
	function automatic frame_status_t judge_transfer(int unsigned total, bit bus_err,
			bit [15:0] trailer_id);
		int unsigned hl;
		int unsigned pl;
		int unsigned pad;
		hl = rx_hdr_len;
		pl = rx_pay_len;
		pad = (pl % 2 == 0) ? 1 : 0;
		if (bus_err) return ST_BUS_ERROR;
		if (total % 2 == 0) return ST_EVEN_LENGTH;
		if (total > shadow_max_len) return ST_TOO_LONG;
		if (pl > shadow_max_len) return ST_LEN_TOO_BIG;
		if (hl < HDR_MIN) return ST_HDR_SHORT;
		if (hl > pl) return ST_HDR_OVER_LEN;
		if (pad == 1 && !rx_pad_ok) return ST_BAD_PAD;
		if (total != hl + pl + 2 + pad) return ST_LEN_MISMATCH;
		if (rx_hdr_id != trailer_id) return ST_ID_MISMATCH;
		if (pl == 0) return ST_EMPTY;
		return ST_OK;
	endfunction

	// Advances the shadow state by one accepted byte and queues what it produces.
	task automatic predict_byte(input bit [7:0] b, input bit last, input bit bus_err);
		int unsigned     p;
		int unsigned     window_end;
		deframe_result_t r;
		p = rx_pos;
		case (p)
			0: rx_hdr_len = {8'h00, b};
			1: rx_hdr_len[15:8] = b;
			2: rx_pay_len = {8'h00, b};
			3: rx_pay_len[15:8] = b;
			4: rx_hdr_id = {8'h00, b};
			5: rx_hdr_id[15:8] = b;
			default: ;
		endcase
		window_end = int'(rx_hdr_len) + int'(rx_pay_len);
		if (p >= HDR_MIN && p == window_end)
			rx_pad_ok = (b == PAD_VALUE);
		if (last) begin
			r.is_verdict = 1'b1;
			r.payload_byte = 8'h00;
			r.frame_status = judge_transfer(p + 1, bus_err, {b, rx_prev_byte});
			r.frame_id = rx_hdr_id;
			r.frame_length = rx_pay_len;
			pending_results.push_back(r);
			rx_pos = '0;
			rx_hdr_len = '0;
			rx_pay_len = '0;
			rx_hdr_id = '0;
			rx_prev_byte = '0;
			rx_pad_ok = 1'b0;
		end else begin
			// The payload window ignores header sanity; the verdict decides later.
			if (p >= HDR_MIN && p >= rx_hdr_len && p < window_end) begin
				r.is_verdict = 1'b0;
				r.payload_byte = b;
				r.frame_status = ST_OK;
				r.frame_id = '0;
				r.frame_length = '0;
				pending_results.push_back(r);
			end
			rx_prev_byte = b;
			if (rx_pos != 16'hFFFF)
				rx_pos++;
		end
	endtask

	// Offers one byte request and returns at the edge where it is taken.
	task automatic send_byte(input bit [7:0] b, input bit last, input bit bus_err);
		int gap;
		gap = tx_steady ? 0 : random_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		s_axis_tuser <= bus_err;
		do @(posedge clk); while (!s_axis_tready);
		predict_byte(b, last, bus_err);
		bytes_sent++;
	endtask

	// Sends tx_frame; the error flag only matters on the final byte, so others get noise.
	task automatic send_frame(input bit bus_err);
		int n;
		n = tx_frame.size();
		for (int i = 0; i < n; i++)
			send_byte(tx_frame[i], i == n - 1, (i == n - 1) ? bus_err : 1'($urandom));
	endtask

	// Header, extra header bytes, payload, pad when the payload is even, trailer id.
	task automatic build_frame(input bit [15:0] hl, input bit [15:0] pl, input bit [15:0] id);
		tx_frame.delete();
		tx_frame.push_back(hl[7:0]);
		tx_frame.push_back(hl[15:8]);
		tx_frame.push_back(pl[7:0]);
		tx_frame.push_back(pl[15:8]);
		tx_frame.push_back(id[7:0]);
		tx_frame.push_back(id[15:8]);
		for (int i = HDR_MIN; i < hl; i++)
			tx_frame.push_back(8'($urandom));
		for (int i = 0; i < pl; i++)
			tx_frame.push_back(8'($urandom));
		if (!pl[0])
			tx_frame.push_back(PAD_VALUE);
		tx_frame.push_back(id[7:0]);
		tx_frame.push_back(id[15:8]);
	endtask

	// Stops offering input and waits until the block has drained, results and all.
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// Bytes that produce nothing may still sit in the two pipeline stages.
		repeat (6) @(posedge clk);
	endtask

	task automatic write_max_len(input bit [15:0] value);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_max_len = value;
	endtask

	// One directed frame for each verdict and for the corner cases of the parser.
	task automatic test_status_codes();
		build_frame(6, 5, 16'h1234);
		send_frame(1'b0);
		write_max_len(16'd40);
		// Clean frames: odd payload without pad, even payload with pad, extra header bytes.
		build_frame(6, 5, 16'hFFFF);
		send_frame(1'b0);
		build_frame(6, 6, 16'h0000);
		send_frame(1'b0);
		build_frame(8, 9, 16'hA55A);
		send_frame(1'b0);
		// Bus error reported on the final byte.
		build_frame(6, 5, 16'h0102);
		send_frame(1'b1);
		// Pad byte removed, so the transfer length turns even.
		build_frame(6, 4, 16'h0304);
		tx_frame.delete(10);
		send_frame(1'b0);
		// Transfer longer than the limit.
		build_frame(6, 41, 16'h0506);
		send_frame(1'b0);
		// Header payload length above the limit while the transfer itself is short.
		build_frame(6, 5, 16'h0708);
		tx_frame[2] = 8'd50;
		send_frame(1'b0);
		// Header length below the fixed six bytes.
		build_frame(3, 5, 16'h090A);
		send_frame(1'b0);
		// Header longer than the payload length.
		build_frame(8, 5, 16'h0B0C);
		send_frame(1'b0);
		// Wrong pad value.
		build_frame(6, 4, 16'h0D0E);
		tx_frame[10] = 8'hAB;
		send_frame(1'b0);
		// Transfer ends before the pad position is reached.
		build_frame(6, 20, 16'h0F10);
		while (tx_frame.size() > 11)
			void'(tx_frame.pop_back());
		send_frame(1'b0);
		// Two stray bytes make the total disagree with the header.
		build_frame(6, 5, 16'h1112);
		tx_frame.insert(8, 8'h00);
		tx_frame.insert(8, 8'hFF);
		send_frame(1'b0);
		// Trailer id differs from the header id.
		build_frame(6, 5, 16'h1314);
		tx_frame[tx_frame.size() - 1] ^= 8'h80;
		send_frame(1'b0);
		// An empty payload is always caught earlier by the header checks.
		build_frame(6, 0, 16'h1516);
		send_frame(1'b0);
		// Transfers of one and two bytes leave most header fields at zero.
		tx_frame = '{8'h07};
		send_frame(1'b0);
		tx_frame = '{8'h06};
		send_frame(1'b1);
		tx_frame = '{8'h06, 8'h00};
		send_frame(1'b0);
		// All-ones header on a short transfer.
		tx_frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		send_frame(1'b0);
	endtask

	// Limit register at zero, at an exact boundary and at full scale.
	task automatic test_config_extremes();
		write_max_len(16'h0000);
		build_frame(6, 5, 16'h2021);
		send_frame(1'b0);
		write_max_len(16'd13);
		build_frame(6, 5, 16'h2223);
		send_frame(1'b0);
		build_frame(6, 6, 16'h2425);
		send_frame(1'b0);
		write_max_len(16'hFFFF);
		build_frame(6, 5, 16'h2627);
		send_frame(1'b0);
		build_frame(6, 5, 16'h2829);
		tx_frame[2] = 8'hFF;
		tx_frame[3] = 8'hFF;
		send_frame(1'b0);
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_output_hold();
		write_max_len(MAX_LEN_RESET);
		tx_steady = 1'b1;
		rx_hold_len = 400;
		build_frame(6, 30, 16'h3132);
		send_frame(1'b0);
		build_frame(7, 13, 16'h3334);
		send_frame(1'b0);
		tx_steady = 1'b0;
	endtask

	// Mostly well-formed frames with random content, some damaged, some noise or cut short.
	task automatic random_frame();
		int kind;
		int hl;
		int pl;
		int k;
		bit bus_err;
		kind = $urandom_range(0, 99);
		hl = HDR_MIN + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
		pl = $urandom_range(hl, hl + 24);
		bus_err = ($urandom_range(0, 9) == 0);
		tx_steady = ($urandom_range(0, 7) == 0);
		rx_steady = ($urandom_range(0, 7) == 0);
		build_frame(16'(hl), 16'(pl), 16'($urandom));
		if (kind >= 65 && kind < 80) begin
			k = $urandom_range(HDR_MIN, tx_frame.size() - 1);
			case ($urandom_range(0, 4))
				0: tx_frame[tx_frame.size() - 1] ^= 8'(1 << $urandom_range(0, 7));
				1: tx_frame[hl + pl] = 8'($urandom);
				2: tx_frame.insert(k, 8'($urandom));
				3: tx_frame.delete(k);
				default: tx_frame[$urandom_range(0, 5)] = 8'($urandom);
			endcase
		end else if (kind >= 80 && kind < 90) begin
			tx_frame.delete();
			repeat ($urandom_range(1, 20))
				tx_frame.push_back(8'($urandom));
		end else if (kind >= 90) begin
			k = $urandom_range(1, tx_frame.size() - 1);
			while (tx_frame.size() > k)
				void'(tx_frame.pop_back());
		end
		send_frame(bus_err);
	endtask

	task automatic test_random_traffic();
		int phase_end;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_max_len(MAX_LEN_RESET);
				1: write_max_len(16'($urandom_range(12, 50)));
				2: write_max_len(16'($urandom));
				default: write_max_len(16'hFFFF);
			endcase
			phase_end = bytes_sent + 370;
			while (bytes_sent < phase_end)
				random_frame();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Receiver: random stalls, plus a long hold counted here when a test asks for one.
	always @(posedge clk) begin
		if (rx_hold_len != 0) begin
			rx_stall_left = rx_hold_len;
			rx_hold_len = 0;
		end
		if (rx_stall_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!rx_steady && $urandom_range(0, 2) == 0)
				rx_stall_left = random_gap();
		end
	end

	// Compares every output request with the oldest prediction.
	always @(posedge clk) begin
		deframe_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected request: verdict=%0b byte=%02h status=%0d id=%04h len=%0d",
						m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8],
						m_axis_tdata[27:12], m_axis_tdata[43:28]);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.is_verdict || m_axis_tdata[7:0] !== want.payload_byte ||
						m_axis_tdata[11:8] !== want.frame_status ||
						m_axis_tdata[27:12] !== want.frame_id ||
						m_axis_tdata[43:28] !== want.frame_length) begin
					if (mismatch_count < 10) begin
						$write("mismatch: expected verdict=%0b byte=%02h status=%0d id=%04h len=%0d, ",
							want.is_verdict, want.payload_byte, want.frame_status,
							want.frame_id, want.frame_length);
						$display("got verdict=%0b byte=%02h status=%0d id=%04h len=%0d",
							m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8],
							m_axis_tdata[27:12], m_axis_tdata[43:28]);
					end
					mismatch_count++;
				end
			end
		end
	end

	// Ends the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 4000) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_status_codes();
		test_config_extremes();
		test_output_hold();
		test_random_traffic();
		drain_block();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
